// File: design/ror_pkg.sv
// ----------------------------------------------------------------------------
// ror_pkg
// shared types and constants of the in-order release reorder buffer
// ----------------------------------------------------------------------------
package ror_pkg;

    localparam int WINDOW_DEF      = 16;
    localparam int HANDLE_BITS_DEF = 8;
    localparam int SEQ_BITS        = 32;

    typedef enum logic [1:0] {
        STATUS_RELEASED      = 2'd0,
        STATUS_DUPLICATE     = 2'd1,
        STATUS_OUT_OF_WINDOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DRAIN
    } state_t;

    // everything of one result except the handle, whose width is a parameter
    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        status_t             status;
        logic                last;
    } result_t;

endpackage

// File: design/in_order_release_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// in_order_release_reorder_buffer_core
// releases sequence-tagged chunk handles strictly in sequence order
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries seq_number and chunk_handle.
//   output channel (out_valid / out_stall) carries out_handle, out_seq,
//   status and last_of_run; last_of_run marks the final result of a request.
//   a request with the next expected number is released, followed by every
//   consecutively numbered parked handle. a number 1 to WINDOW-1 ahead is
//   parked and gives no result. a duplicate or out-of-window number gives a
//   single error result.
// timing:
//   one request is accepted, then the decide state follows; parking and
//   error requests then return to idle, a release drains the parked run.
//   the drain rate is set by the handle ram read port, one read per cycle
//   unless stalled. in_stall is high while a request is being worked on.
// stall:
//   results go through one output register; while out_stall holds it full,
//   decide steps that give a result and drain steps wait, and nothing is lost.
// reset:
//   rst_n clears next expected to zero and all slot valid bits at once; the
//   handle ram needs no clearing since a slot is only read when valid.
// ----------------------------------------------------------------------------
module in_order_release_reorder_buffer_core #(
    parameter int WINDOW      = ror_pkg::WINDOW_DEF,
    parameter int HANDLE_BITS = ror_pkg::HANDLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            seq_number,
    input  logic [HANDLE_BITS-1:0] chunk_handle,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [31:0]            out_seq,
    output logic [1:0]             status,
    output logic                   last_of_run
);

    localparam int SLOT_W = $clog2(WINDOW);

    // fsm
    ror_pkg::state_t state_reg, state_next;

    // captured request (payload, no reset)
    logic [31:0]            seq_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    // window position
    logic [31:0]       next_exp_reg, next_exp_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic              slot_valid_reg [WINDOW];

    // slot address arithmetic
    logic [31:0]       offset;
    logic              in_window;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] next_base;
    logic              more;

    // control
    logic              set_en;
    logic              clr_en;
    logic              ram_we;
    logic              ram_re;
    logic [HANDLE_BITS-1:0] ram_rdata;
    logic              load;
    logic              out_free;
    ror_pkg::result_t  res;
    logic [HANDLE_BITS-1:0] res_handle;

    // offset of the request from the next expected number, modulo 2^32
    assign offset    = seq_reg - next_exp_reg;
    assign in_window = offset < 32'(WINDOW);

    // slot of the request: base plus offset, wrapped once around the window
    assign slot_sum = {1'b0, base_reg} + {1'b0, offset[SLOT_W-1:0]};
    assign slot_idx = (slot_sum >= (SLOT_W+1)'(WINDOW))
                    ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW))
                    : slot_sum[SLOT_W-1:0];

    // slot that follows the base, and whether it holds a parked handle
    assign next_base = (base_reg == SLOT_W'(WINDOW - 1)) ? '0 : base_reg + 1'b1;
    assign more      = slot_valid_reg[next_base];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ror_pkg::ST_IDLE;
            next_exp_reg <= '0;
            base_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            seq_reg    <= seq_number;
            handle_reg <= chunk_handle;
        end
    end

    // valid bits, cleared at once by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (set_en)
            begin
                slot_valid_reg[slot_idx] <= 1'b1;
            end
            if (clr_en)
            begin
                slot_valid_reg[base_reg] <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        next_exp_next = next_exp_reg;
        base_next     = base_reg;
        in_stall      = 1'b1;
        set_en        = 1'b0;
        clr_en        = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        load          = 1'b0;
        res.seq       = seq_reg;
        res.status    = ror_pkg::STATUS_RELEASED;
        res.last      = 1'b1;
        res_handle    = handle_reg;

        case (state_reg)
            ror_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ror_pkg::ST_DECIDE;
                end
            end

            ror_pkg::ST_DECIDE:
            begin
                if (!in_window)
                begin
                    res.status = ror_pkg::STATUS_OUT_OF_WINDOW;
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ror_pkg::ST_IDLE;
                    end
                end
                else if (offset != '0)
                begin
                    if (slot_valid_reg[slot_idx])
                    begin
                        res.status = ror_pkg::STATUS_DUPLICATE;
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = ror_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        // park the handle in its slot
                        set_en     = 1'b1;
                        ram_we     = 1'b1;
                        state_next = ror_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // in-order release, start draining if the next slot is held
                    res.last = !more;
                    if (out_free)
                    begin
                        load          = 1'b1;
                        next_exp_next = next_exp_reg + 32'd1;
                        base_next     = next_base;
                        if (more)
                        begin
                            ram_re     = 1'b1;
                            state_next = ror_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            state_next = ror_pkg::ST_IDLE;
                        end
                    end
                end
            end

            ror_pkg::ST_DRAIN:
            begin
                // ram data of the base slot is ready; it holds while stalled
                res.seq    = next_exp_reg;
                res.last   = !more;
                res_handle = ram_rdata;
                if (out_free)
                begin
                    load          = 1'b1;
                    clr_en        = 1'b1;
                    next_exp_next = next_exp_reg + 32'd1;
                    base_next     = next_base;
                    if (more)
                    begin
                        ram_re = 1'b1;
                    end
                    else
                    begin
                        state_next = ror_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ror_pkg::ST_IDLE;
            end
        endcase
    end

    ror_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (WINDOW)
    ) u_handle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (handle_reg),
        .re    (ram_re),
        .raddr (next_base),
        .rdata (ram_rdata)
    );

    ror_out_reg #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .res         (res),
        .res_handle  (res_handle),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_handle  (out_handle),
        .out_seq     (out_seq),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

// File: design/ror_ram.sv
// ----------------------------------------------------------------------------
// ror_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ror_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ror_out_reg.sv
// ----------------------------------------------------------------------------
// ror_out_reg
// output register stage holding one result until the receiver takes it
// ----------------------------------------------------------------------------
module ror_out_reg #(
    parameter int HANDLE_BITS = ror_pkg::HANDLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  ror_pkg::result_t       res,
    input  logic [HANDLE_BITS-1:0] res_handle,
    output logic                   free,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [31:0]            out_seq,
    output logic [1:0]             status,
    output logic                   last_of_run
);

    logic                   valid_reg;
    ror_pkg::result_t       res_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    // slot can take a new result when empty or being drained this cycle
    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            res_reg    <= res;
            handle_reg <= res_handle;
        end
    end

    assign out_valid   = valid_reg;
    assign out_handle  = handle_reg;
    assign out_seq     = res_reg.seq;
    assign status      = res_reg.status;
    assign last_of_run = res_reg.last;

endmodule

// File: design/ror_checker.sv
// ----------------------------------------------------------------------------
// ror_checker
// port-level assertions for the in-order release reorder buffer
// ----------------------------------------------------------------------------
module ror_checker #(
    parameter int HANDLE_BITS = ror_pkg::HANDLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [HANDLE_BITS-1:0] out_handle,
    input logic [31:0]            out_seq,
    input logic [1:0]             status,
    input logic                   last_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_handle)
            && $stable(out_seq) && $stable(status) && $stable(last_of_run))
        else $error("stalled result changed");

    // one request at a time: busy right after an accepted request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in work");

    // an error result is always the only result of its request
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ror_pkg::STATUS_DUPLICATE
            || status == ror_pkg::STATUS_OUT_OF_WINDOW) |-> last_of_run)
        else $error("error result not marked last");

    // while a drain is still running no new request is taken
    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("request accepted in the middle of a drain");

endmodule

bind in_order_release_reorder_buffer_core ror_checker #(
    .HANDLE_BITS (HANDLE_BITS)
) u_ror_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_handle  (out_handle),
    .out_seq     (out_seq),
    .status      (status),
    .last_of_run (last_of_run)
);

// File: sim/in_order_release_reorder_buffer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_release_reorder_buffer_core_tb
// self-checking bench for the in-order release reorder buffer: requests are
// queued by a stimulus process, driven by a clocked sender with random gaps,
// and every result is compared against a scoreboard that tracks the release
// cursor and the parking window of the buffer
// ----------------------------------------------------------------------------
module in_order_release_reorder_buffer_core_tb;

    localparam int WINDOW      = ror_pkg::WINDOW_DEF;
    localparam int HB          = ror_pkg::HANDLE_BITS_DEF;
    localparam int LIMIT       = 100000;  // whole-run watchdog, in cycles
    localparam int LONG_HOLD   = 200;     // receiver hold-off stretch
    localparam int SETTLE      = 3 * WINDOW + 8;  // quiet cycles after the last result

    // one request as offered on the input channel
    typedef struct {
        logic [31:0]   seq;
        logic [HB-1:0] handle;
    } chunk_req_t;

    // one result as seen on the output channel
    typedef struct {
        logic [HB-1:0]    handle;
        logic [31:0]      seq;
        ror_pkg::status_t status;
        logic             last;
    } release_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic          in_stall;
    logic [31:0]   seq_number   = '0;
    logic [HB-1:0] chunk_handle = '0;
    logic          out_valid;
    logic          out_stall    = 1'b0;
    logic [HB-1:0] out_handle;
    logic [31:0]   out_seq;
    logic [1:0]    status;
    logic          last_of_run;

    // stimulus and scoreboard storage
    chunk_req_t pending_reqs[$];
    release_t   expected_releases[$];
    int         reqs_queued = 0;
    int         reqs_taken  = 0;
    int         fail_count  = 0;
    int         cycles      = 0;

    // handshake bookkeeping shared between the edge processes
    bit         req_taken    = 1'b0;
    bit         result_taken = 1'b0;
    bit         hold_off_req = 1'b0;
    int         tx_wait      = 0;
    int         tx_burst     = 0;
    int         rx_wait      = 0;
    int         rx_burst     = 0;
    int         hold_off_left = 0;
    chunk_req_t drive_req;

    // scoreboard copy of the buffer state
    logic [31:0]   next_seq = '0;
    int            head_slot = 0;
    bit            parked_valid[WINDOW];
    logic [HB-1:0] parked_handle[WINDOW];

    // cursor of the stimulus generator: first number not yet handed out
    logic [31:0]   gen_next = '0;

    in_order_release_reorder_buffer_core #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .seq_number   (seq_number),
        .chunk_handle (chunk_handle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_handle   (out_handle),
        .out_seq      (out_seq),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    always #2 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("** in_order_release_reorder_buffer_core: FAILED **");
            $finish;
        end
    end

    // wait count for the next request or result, with occasional gap-free bursts
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(8, 24);
        return $urandom_range(0, 3);
    endfunction

    function automatic void queue_release(input logic [HB-1:0] hdl, input logic [31:0] seq,
                                          input ror_pkg::status_t st, input logic last);
        release_t r;
        r.handle = hdl;
        r.seq    = seq;
        r.status = st;
        r.last   = last;
        expected_releases.push_back(r);
    endfunction

    // scoreboard update for one accepted request
    function automatic void predict_arrival(input logic [31:0] seq, input logic [HB-1:0] hdl);
        logic [31:0] offset;
        int          slot;
        int          n;
        offset = seq - next_seq;
        if (offset >= 32'(WINDOW))
        begin
            // too far ahead, or already released: rejected without storing
            queue_release(hdl, seq, ror_pkg::STATUS_OUT_OF_WINDOW, 1'b1);
        end
        else if (offset != 0)
        begin
            slot = (head_slot + int'(offset)) % WINDOW;
            if (parked_valid[slot])
                queue_release(hdl, seq, ror_pkg::STATUS_DUPLICATE, 1'b1);  // first handle kept
            else
            begin
                parked_valid[slot]  = 1'b1;
                parked_handle[slot] = hdl;
            end
        end
        else
        begin
            // in-order arrival goes out now, then the run of parked successors
            queue_release(hdl, seq, ror_pkg::STATUS_RELEASED, 1'b0);
            n = 1;
            next_seq++;
            head_slot = (head_slot + 1) % WINDOW;
            while (n < WINDOW && parked_valid[head_slot])
            begin
                queue_release(parked_handle[head_slot], next_seq,
                              ror_pkg::STATUS_RELEASED, 1'b0);
                parked_valid[head_slot] = 1'b0;
                n++;
                next_seq++;
                head_slot = (head_slot + 1) % WINDOW;
            end
            expected_releases[expected_releases.size() - 1].last = 1'b1;
        end
    endfunction

    // result check first, then the prediction of any request taken at this edge
    always @(posedge clk)
    begin
        release_t exp_rel;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_taken = 1'b1;
                if (expected_releases.size() == 0)
                begin
                    $error("unexpected result: out_handle %0h out_seq %0h status %0d",
                           out_handle, out_seq, status);
                    fail_count++;
                end
                else
                begin
                    exp_rel = expected_releases.pop_front();
                    if (out_handle !== exp_rel.handle)
                    begin
                        $error("out_handle: expected %0h, got %0h", exp_rel.handle, out_handle);
                        fail_count++;
                    end
                    if (out_seq !== exp_rel.seq)
                    begin
                        $error("out_seq: expected %0h, got %0h", exp_rel.seq, out_seq);
                        fail_count++;
                    end
                    if (status !== exp_rel.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rel.status, status);
                        fail_count++;
                    end
                    if (last_of_run !== exp_rel.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", exp_rel.last, last_of_run);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_arrival(seq_number, chunk_handle);
                reqs_taken++;
                req_taken = 1'b1;
            end
        end
    end

    // sender: holds a stalled request, otherwise waits its drawn gap and offers the next one
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                tx_wait   = draw_wait(tx_burst);
            end
            if (tx_wait > 0 || pending_reqs.size() == 0)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                in_valid <= 1'b0;
            end
            else
            begin
                drive_req = pending_reqs.pop_front();
                seq_number   <= drive_req.seq;
                chunk_handle <= drive_req.handle;
                in_valid     <= 1'b1;
            end
        end
    end

    // receiver: random stall per result, plus a long hold-off when asked for
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                rx_wait      = draw_wait(rx_burst);
            end
            if (hold_off_req)
            begin
                hold_off_req  = 1'b0;
                hold_off_left = LONG_HOLD;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_req(input logic [31:0] seq, input logic [HB-1:0] hdl);
        chunk_req_t r;
        r.seq    = seq;
        r.handle = hdl;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // every queued request taken and every expected result seen
    task automatic wait_drained();
        while (reqs_taken != reqs_queued || expected_releases.size() != 0)
            @(negedge clk);
    endtask

    // mostly shuffled runs of consecutive numbers, with stray and repeated numbers mixed in
    task automatic push_random(input int count);
        chunk_req_t run[$];
        chunk_req_t tmp;
        int         k;
        int         i;
        int         j;
        int         made;
        logic [31:0] seq;
        made = 0;
        while (made < count)
        begin
            run.delete();
            if ($urandom_range(0, 4) != 0)
            begin
                k = ($urandom_range(0, 5) == 0) ? WINDOW : $urandom_range(1, 6);
                for (i = 0; i < k; i++)
                begin
                    tmp.seq    = gen_next + 32'(i);
                    tmp.handle = HB'($urandom);
                    run.push_back(tmp);
                end
                for (i = k - 1; i > 0; i--)
                begin
                    j      = $urandom_range(0, i);
                    tmp    = run[i];
                    run[i] = run[j];
                    run[j] = tmp;
                end
                // repeat one number later in the run: duplicate if still parked,
                // out of window if it has already gone out
                if ($urandom_range(0, 3) == 0)
                begin
                    i      = $urandom_range(0, k - 1);
                    j      = $urandom_range(i + 1, k);
                    tmp    = run[i];
                    tmp.handle = HB'($urandom);
                    run.insert(j, tmp);
                end
                gen_next += 32'(k);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: seq = $urandom;
                    1: seq = gen_next - 32'($urandom_range(1, 40));
                    default: seq = gen_next + 32'(WINDOW) + 32'($urandom_range(0, 500));
                endcase
                tmp.seq    = seq;
                tmp.handle = HB'($urandom);
                run.push_back(tmp);
            end
            foreach (run[i])
                push_req(run[i].seq, run[i].handle);
            made += run.size();
        end
    endtask

    initial
    begin
        int i;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of both fields, every status, a full-window drain
        push_req(32'd0, 8'h00);                     // in order, releases at once
        push_req(32'hFFFF_FFFF, 8'hFF);             // offset wraps to a huge value
        push_req(32'd1 + 32'(WINDOW) - 1, 8'hA5);   // farthest slot of the window
        push_req(32'd1 + 32'(WINDOW), 8'h5A);       // one past the window
        push_req(32'd1 + 32'(WINDOW) - 1, 8'h3C);   // duplicate, first handle stays
        push_req(32'd0, 8'hC3);                     // already released
        for (i = WINDOW - 1; i >= 2; i--)
            push_req(32'(i), HB'(8'h10 + i));       // fill the rest of the window
        push_req(32'd1, 8'hFF);                     // releases the whole window in one run
        gen_next = 32'd1 + 32'(WINDOW);
        wait_drained();

        // receiver holds off while requests keep coming, so the buffer backs up
        hold_off_req = 1'b1;
        push_random(43);
        wait_drained();

        push_random(43);
        // sender pauses here until every result is back
        wait_drained();
        push_random(43);
        wait_drained();

        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && expected_releases.size() == 0)
            $display("** in_order_release_reorder_buffer_core: PASSED **");
        else
            $display("** in_order_release_reorder_buffer_core: FAILED **");
        $finish;
    end

endmodule
